FILE: sv/ir_remote_rgb_dimmer_control_core_defines.svh
// Assertion macros shared by the IR dimmer control RTL
`ifndef IR_REMOTE_RGB_DIMMER_CONTROL_CORE_DEFINES_SVH
`define IR_REMOTE_RGB_DIMMER_CONTROL_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define IRDIM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irdim assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define IRDIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irdim assertion failed");

`endif

FILE: sv/irdim_pkg.sv
// Types and constants for the IR remote dimmer control block
`default_nettype none
package irdim_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CODE_POWER    = 3'd0,
    REG_CODE_PLUS     = 3'd1,
    REG_CODE_MINUS    = 3'd2,
    REG_CODE_NEXT     = 3'd3,
    REG_CODE_PREVIOUS = 3'd4,
    REG_HOLD_INTERVAL = 3'd5,
    REG_STEP_RATIO    = 3'd6,
    REG_MAX_LEVEL     = 3'd7
  } cfg_reg_t;

  // Hold acceleration: one extra step unit per 100 ms held, step capped
  localparam int unsigned HOLD_UNIT_MS  = 100;
  localparam int unsigned HOLD_STEP_CAP = 300;
  // Beyond this hold time the step is always at the cap (ratio >= 1)
  localparam int unsigned HOLD_SAT_MS   = HOLD_UNIT_MS * HOLD_STEP_CAP;
  // held/100 for held < 30000: (held * 5243) >> 19 is exact
  localparam int unsigned RECIP_SHIFT   = 19;
  localparam int unsigned RECIP_MUL     = ((1 << RECIP_SHIFT) / HOLD_UNIT_MS) + 1;

  // Register reset values
  localparam logic [31:0] RST_CODE_POWER    = 32'd0;
  localparam logic [31:0] RST_CODE_PLUS     = 32'd1;
  localparam logic [31:0] RST_CODE_MINUS    = 32'd2;
  localparam logic [31:0] RST_CODE_NEXT     = 32'd3;
  localparam logic [31:0] RST_CODE_PREVIOUS = 32'd4;
  localparam logic [15:0] RST_HOLD_INTERVAL = 16'd100;
  localparam logic [8:0]  RST_STEP_RATIO    = 9'd1;
  localparam logic [15:0] RST_MAX_LEVEL     = 16'd1023;

endpackage
`default_nettype wire

FILE: sv/ir_remote_rgb_dimmer_control_core.sv
// IR remote dimmer control: three-level pipeline plus state/output register
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | button_code, is_repeat, now_ms
//   out     | out_valid/out_stall| level_red, level_green, level_blue,
//           |                    | selected_channel
//   cfg     | cfg_write          | cfg_index, cfg_data
//
// One word per cycle sustained while out_stall stays low; an accepted word passes
// through the stage 1, 2 and 3 registers and then the state registers.
// Stage 1 forms the hold time, stage 2 divides it by 100 (reciprocal multiply),
// stage 3 forms the hold step (multiply and cap), stage 4 updates the state,
// whose registers are the result word.
// Synchronous active-high reset; no clearing pass. A stalled result holds the
// pipeline only as far back as its stages are full.
`default_nettype none
module ir_remote_rgb_dimmer_control_core
  import irdim_pkg::*;
#(
  parameter int NUM_CHANNELS = 3,
  parameter int MIN_LEVEL    = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] button_code,
  input  wire logic        is_repeat,
  input  wire logic [31:0] now_ms,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      level_red,
  output logic [15:0]      level_green,
  output logic [15:0]      level_blue,
  output logic [1:0]       selected_channel,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

`include "ir_remote_rgb_dimmer_control_core_defines.svh"

  localparam logic [1:0]  TOP_CHAN = 2'(NUM_CHANNELS - 1);
  localparam logic [15:0] MIN_LVL  = 16'(MIN_LEVEL);

  // configuration registers
  logic [31:0] code_power, code_plus, code_minus, code_next, code_previous;
  logic [15:0] hold_interval_ms;
  logic [8:0]  step_ratio;
  logic [15:0] max_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_power       <= RST_CODE_POWER;
      code_plus        <= RST_CODE_PLUS;
      code_minus       <= RST_CODE_MINUS;
      code_next        <= RST_CODE_NEXT;
      code_previous    <= RST_CODE_PREVIOUS;
      hold_interval_ms <= RST_HOLD_INTERVAL;
      step_ratio       <= RST_STEP_RATIO;
      max_level        <= RST_MAX_LEVEL;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CODE_POWER:    code_power       <= cfg_data;
        REG_CODE_PLUS:     code_plus        <= cfg_data;
        REG_CODE_MINUS:    code_minus       <= cfg_data;
        REG_CODE_NEXT:     code_next        <= cfg_data;
        REG_CODE_PREVIOUS: code_previous    <= cfg_data;
        REG_HOLD_INTERVAL: hold_interval_ms <= cfg_data[15:0];
        REG_STEP_RATIO:    step_ratio       <= cfg_data[8:0];
        REG_MAX_LEVEL:     max_level        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage ready chain
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept, fire2, fire3, fire4;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;
  assign fire2    = v1 && rdy2;
  assign fire3    = v2 && rdy3;
  assign fire4    = v3 && rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= accept || (v1 && !fire2);
      v2        <= fire2  || (v2 && !fire3);
      v3        <= fire3  || (v3 && !fire4);
      out_valid <= fire4  || (out_valid && out_stall);
    end
  end

  // press start time follows accepted words in order, so it lives at the input
  logic [31:0] press_start_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start_time <= '0;
    end else if (accept && !is_repeat) begin
      press_start_time <= now_ms;
    end
  end

  // stage 1: capture word and hold time
  logic [31:0] s1_code, s1_now, s1_held;
  logic        s1_rep;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code <= button_code;
      s1_rep  <= is_repeat;
      s1_now  <= now_ms;
      s1_held <= now_ms - press_start_time;
    end
  end

  // stage 2: held / 100, saturated where the step is capped anyway
  logic [27:0] recip_prod;
  logic [8:0]  q_next;
  logic [31:0] s2_code, s2_now;
  logic        s2_rep;
  logic [8:0]  s2_q;

  assign recip_prod = 28'(s1_held[14:0]) * 28'(RECIP_MUL);
  assign q_next     = (s1_held >= 32'(HOLD_SAT_MS)) ? 9'(HOLD_STEP_CAP)
                                                    : recip_prod[27:19];

  always_ff @(posedge clk) begin
    if (fire2) begin
      s2_code <= s1_code;
      s2_rep  <= s1_rep;
      s2_now  <= s1_now;
      s2_q    <= q_next;
    end
  end

  // stage 3: hold step = (1 + q) * ratio, capped
  logic [18:0] hold_prod;
  logic [8:0]  hstep_next;
  logic [31:0] s3_code, s3_now;
  logic        s3_rep;
  logic [8:0]  s3_hstep;

  assign hold_prod  = 19'(10'(s2_q) + 10'd1) * 19'(step_ratio);
  assign hstep_next = (hold_prod > 19'(HOLD_STEP_CAP)) ? 9'(HOLD_STEP_CAP)
                                                       : hold_prod[8:0];

  always_ff @(posedge clk) begin
    if (fire3) begin
      s3_code  <= s2_code;
      s3_rep   <= s2_rep;
      s3_now   <= s2_now;
      s3_hstep <= hstep_next;
    end
  end

  // stage 4: state update; the state registers form the result word
  logic [15:0] levels [3];
  logic [1:0]  cur_chan;
  logic [31:0] last_button, last_step_time;

  logic [15:0] levels_next [3];
  logic [1:0]  cur_chan_next;
  logic [31:0] last_button_next, last_step_time_next;

  logic [15:0] lvl, lvl_up, lvl_down;
  logic [8:0]  step_use;
  logic [16:0] up_sum, down_floor;
  logic        rep_plus, rep_minus, rep_due;

  always_comb begin
    case (cur_chan)
      2'd1:    lvl = levels[1];
      2'd2:    lvl = levels[2];
      default: lvl = levels[0];
    endcase
  end

  assign step_use   = s3_rep ? s3_hstep : step_ratio;
  assign up_sum     = 17'(lvl) + 17'(step_use);
  assign lvl_up     = (up_sum < 17'(max_level)) ? up_sum[15:0] : max_level;
  assign down_floor = 17'(MIN_LVL) + 17'(step_use);
  assign lvl_down   = (17'(lvl) < down_floor) ? MIN_LVL : lvl - 16'(step_use);

  assign rep_plus  = (last_button == code_plus);
  assign rep_minus = !rep_plus && (last_button == code_minus);
  assign rep_due   = ((s3_now - last_step_time) >= 32'(hold_interval_ms));

  always_comb begin
    levels_next         = levels;
    cur_chan_next       = cur_chan;
    last_button_next    = last_button;
    last_step_time_next = last_step_time;
    if (fire4) begin
      if (s3_rep) begin
        // held plus/minus, paced by the hold interval
        if ((rep_plus || rep_minus) && rep_due) begin
          levels_next[cur_chan] = rep_plus ? lvl_up : lvl_down;
          last_step_time_next   = s3_now;
        end
      end else begin
        // new press; first matching code wins
        last_button_next    = s3_code;
        last_step_time_next = s3_now;
        if (s3_code == code_power) begin
          for (int i = 0; i < 3; i++) begin
            if (i < NUM_CHANNELS) levels_next[i] = '0;
          end
        end else if (s3_code == code_plus) begin
          if (lvl < max_level) levels_next[cur_chan] = lvl_up;
        end else if (s3_code == code_minus) begin
          if (lvl > MIN_LVL) levels_next[cur_chan] = lvl_down;
        end else if (s3_code == code_next) begin
          cur_chan_next = (cur_chan >= TOP_CHAN) ? 2'd0 : cur_chan + 2'd1;
        end else if (s3_code == code_previous) begin
          cur_chan_next = (cur_chan == 2'd0) ? TOP_CHAN : cur_chan - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels         <= '{default: '0};
      cur_chan       <= '0;
      last_button    <= '0;
      last_step_time <= '0;
    end else begin
      levels         <= levels_next;
      cur_chan       <= cur_chan_next;
      last_button    <= last_button_next;
      last_step_time <= last_step_time_next;
    end
  end

  assign level_red        = levels[0];
  assign level_green      = levels[1];
  assign level_blue       = levels[2];
  assign selected_channel = cur_chan;

  // checks
  `IRDIM_ASSERT_IMPL(a_chan_in_range, 1'b1, cur_chan <= TOP_CHAN)
  `IRDIM_ASSERT_IMPL(a_empty_pipe_takes_word, !v1, !in_stall)
  `IRDIM_ASSERT_NEXT(a_update_gives_result, fire4, out_valid)
  `IRDIM_ASSERT_IMPL(a_unused_chan_zero, NUM_CHANNELS < 3, levels[2] == 16'd0)

endmodule
`default_nettype wire
